// ===== src/assert_macros.svh =====
// Assertion macros shared by the lexer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define ASSERT_IMPLY(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, reset masked.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/cslx_pkg.sv =====
// Shared types, token codes and keyword lookup for the character stream lexer.
// No dependencies; used by cslx_scan, cslx_tok_fifo and char_stream_lexer_top.
package cslx_pkg;

    localparam int CHAR_W   = 8;
    localparam int TOK_W    = 5;
    localparam int LIMIT_W  = 16;
    localparam int NUM_W    = 17;          // holds the saturation value 65536
    localparam int ID_MAX   = 8;
    localparam int ID_LEN_W = 4;           // 0..9
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = Q_PTR_W + 1;

    localparam logic [NUM_W-1:0] NUM_SAT = NUM_W'(65536);

    // token codes
    localparam logic [TOK_W-1:0] TOK_END    = 5'd0;
    localparam logic [TOK_W-1:0] TOK_BEGIN  = 5'd1;
    localparam logic [TOK_W-1:0] TOK_IF     = 5'd2;
    localparam logic [TOK_W-1:0] TOK_THEN   = 5'd3;
    localparam logic [TOK_W-1:0] TOK_WHILE  = 5'd4;
    localparam logic [TOK_W-1:0] TOK_DO     = 5'd5;
    localparam logic [TOK_W-1:0] TOK_ENDKW  = 5'd6;
    localparam logic [TOK_W-1:0] TOK_IDENT  = 5'd10;
    localparam logic [TOK_W-1:0] TOK_NUMBER = 5'd11;
    localparam logic [TOK_W-1:0] TOK_MUL    = 5'd13;
    localparam logic [TOK_W-1:0] TOK_DIV    = 5'd14;
    localparam logic [TOK_W-1:0] TOK_ADD    = 5'd15;
    localparam logic [TOK_W-1:0] TOK_SUB    = 5'd16;
    localparam logic [TOK_W-1:0] TOK_COLON  = 5'd17;
    localparam logic [TOK_W-1:0] TOK_ASSIGN = 5'd18;
    localparam logic [TOK_W-1:0] TOK_GT     = 5'd20;
    localparam logic [TOK_W-1:0] TOK_NE     = 5'd21;
    localparam logic [TOK_W-1:0] TOK_LE     = 5'd22;
    localparam logic [TOK_W-1:0] TOK_LT     = 5'd23;
    localparam logic [TOK_W-1:0] TOK_GE     = 5'd24;
    localparam logic [TOK_W-1:0] TOK_EQ     = 5'd25;
    localparam logic [TOK_W-1:0] TOK_SEMI   = 5'd26;
    localparam logic [TOK_W-1:0] TOK_LPAREN = 5'd27;
    localparam logic [TOK_W-1:0] TOK_RPAREN = 5'd28;
    localparam logic [TOK_W-1:0] TOK_ERROR  = 5'd31;

    typedef logic [ID_MAX-1:0][CHAR_W-1:0] id_buf_t;

    // tokens produced by one character, oldest in code0
    typedef struct packed {
        logic [1:0]       n;
        logic [TOK_W-1:0] code0;
        logic [TOK_W-1:0] code1;
    } tok_push_t;

    // identifier or keyword code for a finished letter run
    function automatic logic [TOK_W-1:0] ident_code(input id_buf_t b,
                                                   input logic [ID_LEN_W-1:0] len);
        logic [2*CHAR_W-1:0] w2;
        logic [3*CHAR_W-1:0] w3;
        logic [4*CHAR_W-1:0] w4;
        logic [5*CHAR_W-1:0] w5;
        logic [TOK_W-1:0]    code;
        w2 = {b[0], b[1]};
        w3 = {b[0], b[1], b[2]};
        w4 = {b[0], b[1], b[2], b[3]};
        w5 = {b[0], b[1], b[2], b[3], b[4]};
        code = TOK_IDENT;
        if (len > ID_LEN_W'(ID_MAX))
            code = TOK_ERROR;
        else if (len == 4'd5 && w5 == "begin")
            code = TOK_BEGIN;
        else if (len == 4'd2 && w2 == "if")
            code = TOK_IF;
        else if (len == 4'd4 && w4 == "then")
            code = TOK_THEN;
        else if (len == 4'd5 && w5 == "while")
            code = TOK_WHILE;
        else if (len == 4'd2 && w2 == "do")
            code = TOK_DO;
        else if (len == 4'd3 && w3 == "end")
            code = TOK_ENDKW;
        return code;
    endfunction

endpackage

// ===== src/char_stream_lexer_top.sv =====
// Character stream lexer: one ASCII byte per request in, token codes out.
// Accepts a character every clock while the token queue has room for two tokens; each
// character waits in the input register, where the scan logic turns it into zero, one
// or two tokens that enter a four-entry queue in the same cycle. The sustained rate is one
// character per clock while out_stall is low; it is set by the output port, which delivers
// one token a clock, so a character that ends a pending run and is itself a token adds a
// second token, absorbed by the queue. Runs and two-character operators are held until
// the character that ends them arrives. number_limit (reset 32767) may be written only
// while the block is idle. Depends on cslx_pkg, cslx_scan and cslx_tok_fifo.
module char_stream_lexer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cslx_pkg::LIMIT_W-1:0]  cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cslx_pkg::CHAR_W-1:0]   in_char,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cslx_pkg::TOK_W-1:0]    token_code
);

    logic [cslx_pkg::LIMIT_W-1:0] limit_reg;
    logic                         s1_valid_reg, s1_valid_next;
    logic [cslx_pkg::CHAR_W-1:0]  s1_char_reg;
    logic                         room2;
    logic                         advance;
    logic                         accept;
    cslx_pkg::tok_push_t          push;

    // input register drains into the scanner whenever the queue can take two tokens
    assign advance  = s1_valid_reg && room2;
    assign in_stall = s1_valid_reg && !room2;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            limit_reg    <= cslx_pkg::LIMIT_W'(32767);
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_we)
                limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_char_reg <= in_char;
    end

    cslx_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .ch           (s1_char_reg),
        .number_limit (limit_reg),
        .push         (push)
    );

    cslx_tok_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room2      (room2),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_code (token_code)
    );

endmodule

// ===== src/cslx_scan.sv =====
// Lexer scan stage: running mode, identifier buffer and number accumulator.
// Depends on cslx_pkg; produces up to two tokens per character.
module cslx_scan (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [cslx_pkg::CHAR_W-1:0]   ch,
    input  logic [cslx_pkg::LIMIT_W-1:0]  number_limit,
    output cslx_pkg::tok_push_t           push
);

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_IDENT = 3'd1;
    localparam logic [2:0] M_NUM   = 3'd2;
    localparam logic [2:0] M_LT    = 3'd3;
    localparam logic [2:0] M_GT    = 3'd4;
    localparam logic [2:0] M_COLON = 3'd5;

    logic [2:0]                          mode_reg, mode_next;
    cslx_pkg::id_buf_t                   id_buf_reg, id_buf_next;
    logic [cslx_pkg::ID_LEN_W-1:0]       id_len_reg, id_len_next;
    logic [cslx_pkg::NUM_W-1:0]          num_reg, num_next;

    logic                                is_letter, is_numeral;
    logic                                pend_vld, fresh_vld, do_fresh;
    logic [cslx_pkg::TOK_W-1:0]          pend_code, fresh_code;
    logic [cslx_pkg::NUM_W+3:0]          num_acc;

    assign is_letter  = (ch inside {["a":"z"], ["A":"Z"]});
    assign is_numeral = (ch inside {["0":"9"]});
    // num*10 + digit; digit is the low nibble of an ASCII digit
    assign num_acc = ((cslx_pkg::NUM_W+4)'(num_reg) << 3) + ((cslx_pkg::NUM_W+4)'(num_reg) << 1)
                   + (cslx_pkg::NUM_W+4)'(ch[3:0]);

    always_comb
    begin
        mode_next   = mode_reg;
        id_buf_next = id_buf_reg;
        id_len_next = id_len_reg;
        num_next    = num_reg;
        pend_vld    = 1'b0;
        pend_code   = cslx_pkg::TOK_ERROR;
        do_fresh    = 1'b0;
        fresh_vld   = 1'b0;
        fresh_code  = cslx_pkg::TOK_ERROR;

        // pending run or operator
        unique case (mode_reg)
            M_IDENT:
            begin
                if (is_letter || is_numeral)
                begin
                    if (id_len_reg < cslx_pkg::ID_LEN_W'(cslx_pkg::ID_MAX))
                        id_buf_next[id_len_reg[2:0]] = ch;
                    if (id_len_reg <= cslx_pkg::ID_LEN_W'(cslx_pkg::ID_MAX))
                        id_len_next = id_len_reg + 4'd1;
                end
                else
                begin
                    pend_vld  = 1'b1;
                    pend_code = cslx_pkg::ident_code(id_buf_reg, id_len_reg);
                    do_fresh  = 1'b1;
                end
            end
            M_NUM:
            begin
                if (is_numeral)
                begin
                    if (num_acc > (cslx_pkg::NUM_W+4)'(cslx_pkg::NUM_SAT))
                        num_next = cslx_pkg::NUM_SAT;
                    else
                        num_next = num_acc[cslx_pkg::NUM_W-1:0];
                end
                else
                begin
                    pend_vld  = 1'b1;
                    pend_code = (num_reg > {1'b0, number_limit}) ? cslx_pkg::TOK_ERROR
                                                                 : cslx_pkg::TOK_NUMBER;
                    do_fresh  = 1'b1;
                end
            end
            M_LT:
            begin
                pend_vld = 1'b1;
                if (ch == ">")
                begin
                    pend_code = cslx_pkg::TOK_NE;
                    mode_next = M_IDLE;
                end
                else if (ch == "=")
                begin
                    pend_code = cslx_pkg::TOK_LE;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pend_code = cslx_pkg::TOK_LT;
                    do_fresh  = 1'b1;
                end
            end
            M_GT:
            begin
                pend_vld = 1'b1;
                if (ch == "=")
                begin
                    pend_code = cslx_pkg::TOK_GE;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pend_code = cslx_pkg::TOK_GT;
                    do_fresh  = 1'b1;
                end
            end
            M_COLON:
            begin
                pend_vld = 1'b1;
                if (ch == "=")
                begin
                    pend_code = cslx_pkg::TOK_ASSIGN;
                    mode_next = M_IDLE;
                end
                else
                begin
                    pend_code = cslx_pkg::TOK_COLON;
                    do_fresh  = 1'b1;
                end
            end
            default:
                do_fresh = 1'b1;
        endcase

        // the character scanned on its own from idle
        if (do_fresh)
        begin
            mode_next = M_IDLE;
            if (is_letter)
            begin
                id_buf_next    = '0;
                id_buf_next[0] = ch;
                id_len_next    = 4'd1;
                mode_next      = M_IDENT;
            end
            else if (is_numeral)
            begin
                num_next  = cslx_pkg::NUM_W'(ch[3:0]);
                mode_next = M_NUM;
            end
            else
            begin
                fresh_vld = 1'b1;
                case (ch)
                    " ", "\n": fresh_vld  = 1'b0;
                    "<":
                    begin
                        fresh_vld = 1'b0;
                        mode_next = M_LT;
                    end
                    ">":
                    begin
                        fresh_vld = 1'b0;
                        mode_next = M_GT;
                    end
                    ":":
                    begin
                        fresh_vld = 1'b0;
                        mode_next = M_COLON;
                    end
                    "*":       fresh_code = cslx_pkg::TOK_MUL;
                    "/":       fresh_code = cslx_pkg::TOK_DIV;
                    "+":       fresh_code = cslx_pkg::TOK_ADD;
                    "-":       fresh_code = cslx_pkg::TOK_SUB;
                    "=":       fresh_code = cslx_pkg::TOK_EQ;
                    ";":       fresh_code = cslx_pkg::TOK_SEMI;
                    "(":       fresh_code = cslx_pkg::TOK_LPAREN;
                    ")":       fresh_code = cslx_pkg::TOK_RPAREN;
                    "#":       fresh_code = cslx_pkg::TOK_END;
                    default:   fresh_code = cslx_pkg::TOK_ERROR;
                endcase
            end
        end

        // pack oldest first
        push.n     = 2'd0;
        push.code0 = pend_vld ? pend_code : fresh_code;
        push.code1 = fresh_code;
        if (step)
            push.n = 2'(pend_vld) + 2'(fresh_vld);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            id_len_reg <= '0;
            num_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            id_len_reg <= id_len_next;
            num_reg    <= num_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            id_buf_reg <= id_buf_next;
    end

endmodule

// ===== src/cslx_tok_fifo.sv =====
// Token output queue: takes up to two tokens a cycle, delivers one while out_stall is low.
// Depends on cslx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cslx_tok_fifo (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cslx_pkg::tok_push_t          push,
    output logic                         room2,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [cslx_pkg::TOK_W-1:0]   token_code
);

    logic [cslx_pkg::TOK_W-1:0]   q_reg [cslx_pkg::Q_DEPTH];
    logic [cslx_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cslx_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cslx_pkg::Q_CNT_W-1:0] count_reg, count_next;
    logic                         pop;

    assign out_valid  = (count_reg != '0);
    assign token_code = q_reg[rd_ptr_reg];
    assign pop        = out_valid && !out_stall;
    // room for two after this cycle's pop
    assign room2 = ({1'b0, count_reg} <=
                    (cslx_pkg::Q_CNT_W+1)'(cslx_pkg::Q_DEPTH - 2) + (cslx_pkg::Q_CNT_W+1)'(pop));

    assign wr_ptr_next = wr_ptr_reg + cslx_pkg::Q_PTR_W'(push.n);
    assign rd_ptr_next = rd_ptr_reg + cslx_pkg::Q_PTR_W'(pop);
    assign count_next  = count_reg + cslx_pkg::Q_CNT_W'(push.n) - cslx_pkg::Q_CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            q_reg[wr_ptr_reg] <= push.code0;
        if (push.n == 2'd2)
            q_reg[wr_ptr_reg + cslx_pkg::Q_PTR_W'(1)] <= push.code1;
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push.n != 2'd0, (cslx_pkg::Q_CNT_W+1)'(count_reg) + (cslx_pkg::Q_CNT_W+1)'(push.n) <= (cslx_pkg::Q_CNT_W+1)'(cslx_pkg::Q_DEPTH) + (cslx_pkg::Q_CNT_W+1)'(pop))
    `ASSERT_IMPLY(a_push_fits, clk, rst_n, push.n == 2'd2, room2)
    `ASSERT_NEXT(a_idle_hold, clk, rst_n, push.n == 2'd0 && !pop, $stable(count_reg) && $stable(rd_ptr_reg))

endmodule
